/* rtl/capability_slot_linked_table_defines.svh */
// Assertion macros for the capability slot table.
`ifndef CAPABILITY_SLOT_LINKED_TABLE_DEFINES_SVH
`define CAPABILITY_SLOT_LINKED_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define CSL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("capability slot table: same-cycle check failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define CSL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("capability slot table: next-cycle check failed");
`else
`define CSL_ASSERT_SAME(label, ante, cons)
`define CSL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/csl_pkg.sv */
`default_nettype none

package csl_pkg;

   localparam int PROC_COUNT     = 8;
   localparam int SLOTS_PER_PROC = 32;
   localparam int TYPE_BITS      = 4;
   localparam int TOTAL_SLOTS    = PROC_COUNT * SLOTS_PER_PROC;
   localparam int SLOT_W         = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int CAP_W          = 64;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_MOVE   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [7:0]       proc_id;
      logic [7:0]       slot_index;
      logic [7:0]       other_proc_id;
      logic [7:0]       other_slot_index;
      logic [CAP_W-1:0] cap_in;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [CAP_W-1:0] cap_out;
      logic             slot_empty;
      logic [7:0]       next_slot;
      logic [7:0]       prev_slot;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/capability_slot_linked_table.sv */
`default_nettype none
// Capability slot table with doubly linked derivation links.
// Request channel: drive req_data and raise start; the request is taken at a
// rising edge where start is high and busy is low. Commands are read, insert
// after another slot, delete and move to another slot.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_data; the
// receiver cannot stall, so it must take the result in that cycle.
// Flow, accept edge to strobe: a bad slot address is answered straight from
// idle; read, delete and a move onto the same slot pass through lookup and
// exec; insert and move also pass through link. busy drops in the strobe
// cycle, so a new request may be taken at the edge that ends it.
// The steps follow from the registered read of the slot memories and from
// the single write port of each memory: insert and move need two write passes.
// Reset: a clearing pass walks all slots, one per cycle, writing zero words
// and zero links; busy stays high until the pass has reached the last slot.
// One request is in flight at a time, so reads never overlap earlier writes.
`include "capability_slot_linked_table_defines.svh"

module capability_slot_linked_table (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  csl_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output csl_pkg::rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC,
      ST_LINK
   } state_type;

   state_type                  state_ff, state_in;
   csl_pkg::slot_type          clr_ff, clr_in;
   csl_pkg::req_type           req_ff, req_in;
   csl_pkg::slot_type          s_ff, s_in;
   csl_pkg::slot_type          o_ff, o_in;
   csl_pkg::slot_type          p_ff, p_in;
   csl_pkg::slot_type          n_ff, n_in;
   logic [csl_pkg::CAP_W-1:0]  word_ff, word_in;
   csl_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;

   // decoder outputs
   logic                       dec_ok;
   csl_pkg::slot_type          dec_slot;
   csl_pkg::slot_type          dec_other;

   // memories: word, predecessor link, successor link
   logic [csl_pkg::CAP_W-1:0]  cap_mem  [csl_pkg::TOTAL_SLOTS];
   csl_pkg::slot_type          prev_mem [csl_pkg::TOTAL_SLOTS];
   csl_pkg::slot_type          next_mem [csl_pkg::TOTAL_SLOTS];

   logic [csl_pkg::CAP_W-1:0]  cap_rd_ff;
   csl_pkg::slot_type          prev_rd_ff;
   csl_pkg::slot_type          next_rd_ff;
   csl_pkg::slot_type          next_raddr;

   logic                       cap_we, prev_we, next_we;
   csl_pkg::slot_type          cap_waddr, prev_waddr, next_waddr;
   logic [csl_pkg::CAP_W-1:0]  cap_wdata;
   csl_pkg::slot_type          prev_wdata, next_wdata;

   logic                       accept;

   csl_decode u_decode (
      .req        (req_data),
      .ok         (dec_ok),
      .slot       (dec_slot),
      .other_slot (dec_other)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Insert follows the predecessor's successor link; all else reads the slot itself.
   assign next_raddr = (req_ff.cmd == csl_pkg::CMD_INSERT) ? o_ff : s_ff;

   // Memory ports: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_waddr] <= cap_wdata;
      end
      cap_rd_ff <= cap_mem[s_ff];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rd_ff <= prev_mem[s_ff];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_rd_ff <= next_mem[next_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      s_in          = s_ff;
      o_in          = o_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      word_in       = word_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      cap_we     = 1'b0;
      cap_waddr  = s_ff;
      cap_wdata  = '0;
      prev_we    = 1'b0;
      prev_waddr = s_ff;
      prev_wdata = '0;
      next_we    = 1'b0;
      next_waddr = s_ff;
      next_wdata = '0;

      case (state_ff)
         ST_CLEAR: begin
            // Sweep every slot back to an empty word and zero links.
            cap_we     = 1'b1;
            cap_waddr  = clr_ff;
            prev_we    = 1'b1;
            prev_waddr = clr_ff;
            next_we    = 1'b1;
            next_waddr = clr_ff;
            clr_in     = clr_ff + csl_pkg::slot_type'(1);
            if (clr_ff == csl_pkg::SLOT_W'(csl_pkg::TOTAL_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               s_in   = dec_slot;
               o_in   = dec_other;
               if (dec_ok) begin
                  state_in = ST_LOOKUP;
               end else begin
                  // Bad address: answer at once, leave the table untouched.
                  rsp_in        = '0;
                  rsp_in.status = 1'b1;
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         ST_LOOKUP: begin
            // Wait out the memory read latency.
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            word_in           = cap_rd_ff;
            p_in              = prev_rd_ff;
            n_in              = next_rd_ff;
            rsp_in            = '0;
            rsp_in.slot_empty = (cap_rd_ff[csl_pkg::TYPE_BITS-1:0] == '0);
            case (req_ff.cmd)
               csl_pkg::CMD_READ: begin
                  rsp_in.cap_out   = cap_rd_ff;
                  rsp_in.next_slot = 8'(next_rd_ff);
                  rsp_in.prev_slot = 8'(prev_rd_ff);
                  rsp_strobe_in    = 1'b1;
                  state_in         = ST_IDLE;
               end
               csl_pkg::CMD_INSERT: begin
                  // Link the new slot behind its predecessor and store the word.
                  prev_we    = 1'b1;
                  prev_waddr = s_ff;
                  prev_wdata = o_ff;
                  next_we    = 1'b1;
                  next_waddr = s_ff;
                  next_wdata = next_rd_ff;
                  cap_we     = 1'b1;
                  cap_waddr  = s_ff;
                  cap_wdata  = req_ff.cap_in;
                  state_in   = ST_LINK;
               end
               csl_pkg::CMD_DELETE: begin
                  // Clear the word and bridge the neighbors around the slot.
                  rsp_in.cap_out = cap_rd_ff;
                  cap_we         = 1'b1;
                  cap_waddr      = s_ff;
                  next_we        = 1'b1;
                  next_waddr     = prev_rd_ff;
                  next_wdata     = next_rd_ff;
                  prev_we        = 1'b1;
                  prev_waddr     = next_rd_ff;
                  prev_wdata     = prev_rd_ff;
                  rsp_strobe_in  = 1'b1;
                  state_in       = ST_IDLE;
               end
               csl_pkg::CMD_MOVE: begin
                  rsp_in.cap_out = cap_rd_ff;
                  if (s_ff == o_ff) begin
                     // Move onto itself: report the word, change nothing.
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     // Clear the source and hand its links to the destination.
                     cap_we     = 1'b1;
                     cap_waddr  = s_ff;
                     prev_we    = 1'b1;
                     prev_waddr = o_ff;
                     prev_wdata = prev_rd_ff;
                     next_we    = 1'b1;
                     next_waddr = o_ff;
                     next_wdata = next_rd_ff;
                     state_in   = ST_LINK;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_LINK: begin
            // Second write pass: point the neighbors at the slot; a move also stores
            // the word there. The successor target follows the first-pass link.
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            if (req_ff.cmd == csl_pkg::CMD_INSERT) begin
               next_we    = 1'b1;
               next_waddr = o_ff;
               next_wdata = s_ff;
               prev_we    = 1'b1;
               prev_waddr = (o_ff == s_ff) ? s_ff : n_ff;
               prev_wdata = s_ff;
            end else begin
               cap_we     = 1'b1;
               cap_waddr  = o_ff;
               cap_wdata  = word_ff;
               next_we    = 1'b1;
               next_waddr = p_ff;
               next_wdata = o_ff;
               prev_we    = 1'b1;
               prev_waddr = (p_ff == o_ff) ? o_ff : n_ff;
               prev_wdata = o_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff  <= req_in;
      s_ff    <= s_in;
      o_ff    <= o_in;
      p_ff    <= p_in;
      n_ff    <= n_in;
      word_ff <= word_in;
      rsp_ff  <= rsp_in;
   end

   // A result only shows once the block is free for the next request.
   `CSL_ASSERT_SAME(a_strobe_when_free, rsp_strobe, !busy)
   // An accepted request either starts work or answers in the next cycle.
   `CSL_ASSERT_NEXT(a_accept_progress, accept, busy || rsp_strobe)
   // The table is never written while the block waits for requests.
   `CSL_ASSERT_SAME(a_idle_no_write, state_ff == ST_IDLE, !(cap_we || prev_we || next_we))
   // A bad address reports a zero word.
   `CSL_ASSERT_SAME(a_error_zero_word, rsp_strobe && rsp_data.status, rsp_data.cap_out == '0)

endmodule

`default_nettype wire

/* rtl/csl_decode.sv */
`default_nettype none

// Check the slot address of a request, and the other one for insert and move, and form their flat slot numbers.
module csl_decode (
   input  csl_pkg::req_type  req,
   output logic              ok,
   output csl_pkg::slot_type slot,
   output csl_pkg::slot_type other_slot
);

   logic        slot_ok;
   logic        other_ok;
   logic        uses_other;
   logic [15:0] slot_flat;
   logic [15:0] other_flat;

   always_comb begin
      slot_ok  = (9'(req.proc_id) < 9'(csl_pkg::PROC_COUNT)) &&
                 (9'(req.slot_index) < 9'(csl_pkg::SLOTS_PER_PROC));
      other_ok = (9'(req.other_proc_id) < 9'(csl_pkg::PROC_COUNT)) &&
                 (9'(req.other_slot_index) < 9'(csl_pkg::SLOTS_PER_PROC));
      uses_other = (req.cmd == csl_pkg::CMD_INSERT) || (req.cmd == csl_pkg::CMD_MOVE);
      ok = slot_ok && (other_ok || !uses_other);

      slot_flat  = 16'(req.proc_id) * 16'(csl_pkg::SLOTS_PER_PROC) + 16'(req.slot_index);
      other_flat = 16'(req.other_proc_id) * 16'(csl_pkg::SLOTS_PER_PROC) +
                   16'(req.other_slot_index);
      slot       = slot_flat[csl_pkg::SLOT_W-1:0];
      other_slot = other_flat[csl_pkg::SLOT_W-1:0];
   end

endmodule

`default_nettype wire
